### rtl/core/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MLCD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("mlcd assertion failed");

`define MLCD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mlcd assertion failed");

`else

`define MLCD_ASSERT(label, clk, rst_n, prop)

`define MLCD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/core/mlcd_pkg.sv
package mlcd_pkg;

    localparam int SLOT_COUNT = 16;

    localparam logic [3:0] SLOT_START = 4'd1;
    localparam logic [3:0] SLOT_FRAME = 4'd14;

    localparam logic [6:0] SEG_BLANK    = 7'h00;
    localparam logic [6:0] SEG_OVERLOAD = 7'h68;

    localparam logic [3:0] DIG_OVERLOAD = 4'd10;
    localparam logic [3:0] DIG_BLANK    = 4'd11;
    localparam logic [3:0] DIG_UNKNOWN  = 4'd12;

    localparam int DIGIT_COUNT = 10;

    localparam logic [6:0] SEG_DIGITS [DIGIT_COUNT] = '{
        7'h7D, 7'h05, 7'h5B, 7'h1F, 7'h27, 7'h3E, 7'h7E, 7'h15, 7'h7F, 7'h3F
    };

    typedef logic [SLOT_COUNT-1:0][3:0] t_slots;

    typedef struct packed {
        logic       vld;
        logic [3:0] slot;
        logic [3:0] data;
    } t_step;

    typedef struct packed {
        logic advance;
        logic fire;
    } t_ctl;

    typedef struct packed {
        logic       negative;
        logic [3:0] digit_0;
        logic [3:0] digit_1;
        logic [3:0] digit_2;
        logic [3:0] digit_3;
        logic [2:0] point_mask;
        logic [9:0] unit_mask;
        logic [7:0] status_mask;
    } t_result;

    function automatic logic [3:0] decode_digit(input logic [6:0] code);
        logic [3:0] res;
        res = DIG_UNKNOWN;
        if (code == SEG_BLANK) begin
            res = DIG_BLANK;
        end else if (code == SEG_OVERLOAD) begin
            res = DIG_OVERLOAD;
        end else begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if (SEG_DIGITS[i] == code) begin
                    res = 4'(i);
                end
            end
        end
        return res;
    endfunction

endpackage

### rtl/core/mlcd_if.sv
interface mlcd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlcd_res_if;
    logic       valid;
    logic       ready;
    logic       negative;
    logic [3:0] digit_0;
    logic [3:0] digit_1;
    logic [3:0] digit_2;
    logic [3:0] digit_3;
    logic [2:0] point_mask;
    logic [9:0] unit_mask;
    logic [7:0] status_mask;

    modport source (
        output valid, output negative, output digit_0, output digit_1,
        output digit_2, output digit_3, output point_mask, output unit_mask,
        output status_mask, input ready
    );
    modport sink (
        input valid, input negative, input digit_0, input digit_1,
        input digit_2, input digit_3, input point_mask, input unit_mask,
        input status_mask, output ready
    );
endinterface

### rtl/core/mlcd_in_reg.sv
module mlcd_in_reg
    import mlcd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    mlcd_rx_if.sink i_rx,
    input  logic   i_advance,
    output t_step  o_step
);

    logic       r_vld;
    logic [7:0] r_byte;

    assign i_rx.ready = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_step.vld  = r_vld;
    assign o_step.slot = r_byte[7:4];
    assign o_step.data = r_byte[3:0];

endmodule

### rtl/core/mlcd_slots.sv
module mlcd_slots
    import mlcd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_step  i_step,
    input  logic   i_out_free,
    output t_slots o_slots,
    output t_ctl   o_ctl
);

    t_slots r_slots;
    t_slots n_slots;
    logic   r_start;
    logic   frame;

    // store view with the pending byte already written
    always_comb begin
        n_slots = r_slots;
        n_slots[i_step.slot] = i_step.data;
    end

    assign frame         = i_step.vld && (i_step.slot == SLOT_FRAME) && r_start;
    assign o_ctl.advance = i_step.vld && (!frame || i_out_free);
    assign o_ctl.fire    = frame && i_out_free;
    assign o_slots       = n_slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
            r_start <= 1'b0;
        end else if (o_ctl.advance) begin
            r_slots <= n_slots;
            if (i_step.slot == SLOT_START) begin
                r_start <= 1'b1;
            end
        end
    end

endmodule

### rtl/core/mlcd_out_reg.sv
module mlcd_out_reg
    import mlcd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_slots i_slots,
    input  logic   i_fire,
    output logic   o_free,
    mlcd_res_if.source o_res
);

    logic    r_vld;
    t_result r_res;
    t_result n_res;
    logic    hertz;
    logic    ohms;

    assign hertz = i_slots[13][1];
    assign ohms  = i_slots[12][2];

    always_comb begin
        n_res.negative    = i_slots[2][3];
        n_res.digit_0     = decode_digit({i_slots[2][2:0], i_slots[3]});
        n_res.digit_1     = decode_digit({i_slots[4][2:0], i_slots[5]});
        n_res.digit_2     = decode_digit({i_slots[6][2:0], i_slots[7]});
        n_res.digit_3     = decode_digit({i_slots[8][2:0], i_slots[9]});
        n_res.point_mask  = {i_slots[8][3], i_slots[6][3], i_slots[4][3]};
        n_res.unit_mask   = {
            ohms && i_slots[10][1],
            ohms && i_slots[11][1],
            ohms,
            !hertz && i_slots[14][0],
            hertz,
            i_slots[13][2],
            i_slots[13][3],
            i_slots[11][3],
            i_slots[10][3],
            i_slots[10][2]
        };
        n_res.status_mask = {
            i_slots[13][0],
            i_slots[11][0],
            i_slots[11][2],
            i_slots[10][0],
            i_slots[12][1],
            i_slots[12][0],
            i_slots[1][1],
            i_slots[1][3]
        };
    end

    assign o_free = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_fire) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_vld;
    assign o_res.negative    = r_res.negative;
    assign o_res.digit_0     = r_res.digit_0;
    assign o_res.digit_1     = r_res.digit_1;
    assign o_res.digit_2     = r_res.digit_2;
    assign o_res.digit_3     = r_res.digit_3;
    assign o_res.point_mask  = r_res.point_mask;
    assign o_res.unit_mask   = r_res.unit_mask;
    assign o_res.status_mask = r_res.status_mask;

endmodule

### rtl/core/meter_lcd_frame_decoder.sv
// channel   dir   payload                                        transfer
// i_rx      in    rx_byte                                        valid && ready
// o_res     out   negative, digit_0..3, point/unit/status masks  valid && ready
//
// one byte per cycle unless a slot 14 byte waits on a stalled result; a frame result
// is decoded from the input register into the result register and is then valid
// synchronous active-low reset clears the slot store, start flag and valids
// a stalled result holds only a slot 14 byte in the input register; other
// bytes keep flowing into the slot store until that byte is held there
`include "assert_macros.svh"

module meter_lcd_frame_decoder
    import mlcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlcd_rx_if.sink    i_rx,
    mlcd_res_if.source o_res
);

    t_step  w_step;
    t_ctl   w_ctl;
    t_slots w_slots;
    logic   w_out_free;

    mlcd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_ctl.advance),
        .o_step    (w_step)
    );

    mlcd_slots u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_out_free (w_out_free),
        .o_slots    (w_slots),
        .o_ctl      (w_ctl)
    );

    mlcd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slots (w_slots),
        .i_fire  (w_ctl.fire),
        .o_free  (w_out_free),
        .o_res   (o_res)
    );

    `MLCD_ASSERT(a_fire_gives_result, i_clk, i_rst_n, w_ctl.fire |=> o_res.valid)
    `MLCD_ASSERT(a_result_from_fire, i_clk, i_rst_n, $rose(o_res.valid) |-> $past(w_ctl.fire))
    `MLCD_ASSERT(a_stall_holds, i_clk, i_rst_n, w_step.vld && !w_ctl.advance |=> $stable(w_step))
    `MLCD_ASSERT_ALWAYS(a_fire_needs_room, i_clk, w_ctl.fire |-> w_out_free && w_ctl.advance)

endmodule
